@@ src/abd_pkg.sv @@
`timescale 1ns / 1ps

package abd_pkg;

    // Work RAM size and the width of an index into it.
    localparam int RAM_BYTES = 5120;
    localparam int RAM_AW    = $clog2(RAM_BYTES);

    // Access kinds carried in the cmd field.
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_FETCH = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DIP_PORT0 = 2'd0;
    localparam logic [1:0] CFG_DIP_PORT1 = 2'd1;
    localparam logic [1:0] CFG_DIP_PORT2 = 2'd2;

    // Address decode constants, on the 15-bit address with bit 15 dropped.
    localparam logic [3:0]  RAM0_PAGE      = 4'h8;     // 0x4000-0x47FF
    localparam logic [4:0]  RAM1_PAGE      = 5'h14;    // 0x5000-0x53FF
    localparam logic [3:0]  RAM2_PAGE      = 4'hB;     // 0x5800-0x5FFF
    localparam logic [3:0]  PORT0_PAGE     = 4'hC;     // 0x6000-0x67FF
    localparam logic [3:0]  PORT1_PAGE     = 4'hD;     // 0x6800-0x6FFF
    localparam logic [3:0]  PORT2_PAGE     = 4'hE;     // 0x7000-0x77FF
    localparam logic [3:0]  PITCH_PAGE     = 4'hF;     // 0x7800-0x7FFF
    localparam logic [11:0] LFO_GROUP      = 12'hC00;  // 0x6000-0x6007
    localparam logic [11:0] SOUND_GROUP    = 12'hD00;  // 0x6800-0x6807
    localparam logic [11:0] CTRL_GROUP     = 12'hE00;  // 0x7000-0x7007
    localparam logic [2:0]  NMI_OFFSET     = 3'd1;
    localparam logic [2:0]  STARS_OFFSET   = 3'd4;
    localparam logic [14:0] START_MARK     = 15'h5320;
    localparam logic [7:0]  START_IDLE     = 8'h10;
    localparam logic [7:0]  UNMAPPED_DATA  = 8'hFF;

    localparam logic [RAM_AW-1:0] RAM1_BASE = RAM_AW'(12'h800);
    localparam logic [RAM_AW-1:0] RAM2_BASE = RAM_AW'(12'hC00);

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic        btn_coin;
        logic        btn_left;
        logic        btn_right;
        logic        btn_fire;
        logic        btn_start;
    } abd_req_t;

    typedef struct packed {
        logic [7:0]  rdata;
        logic        rom_request;
        logic [13:0] rom_address;
        logic        nmi_enable;
        logic        stars_on;
        logic        started_flag;
        logic [7:0]  vco_pitch;
        logic [3:0]  lfo_bits;
        logic [7:0]  sound_bits;
    } abd_rsp_t;

endpackage

@@ src/arcade_bus_decoder.sv @@
`timescale 1ns / 1ps

// Memory-map decoder for an 8-bit arcade CPU bus.
//
// Each request on the req channel is one bus access (read, write or opcode
// fetch) with its address, write data and button states. Every request gives
// exactly one response on the rsp channel, holding the read data, the ROM
// request and address for an external ROM, and the latch values after the
// access. Three DIP registers are written through the cfg channel, which is
// always ready.
//
// A request accepted into the decode stage moves into the response register
// when it retires and is presented on rsp from there. Throughput is one
// request per cycle while rsp is not stalled: the work RAM is read in the
// cycle of acceptance and written back when the access retires, and a write
// followed at once by a read of the same byte is forwarded around the RAM.
//
// After reset the 5120-byte work RAM is cleared, one byte per cycle, and req is
// stalled until the sweep ends; cfg writes are taken during that time. When the
// receiver stalls rsp, the response holds, one further request can still be
// taken into the decode stage, and req then stalls until rsp moves on.
module arcade_bus_decoder
    import abd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  abd_req_t   req_data,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output abd_rsp_t   rsp_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } abd_state_t;

    abd_state_t state_reg, state_next;
    logic [RAM_AW-1:0] clr_cnt_reg;

    // Work RAM, one write and one read port, registered read data.
    logic [7:0] work_ram [RAM_BYTES];
    logic [7:0] ram_q_reg;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;

    // Configuration registers.
    logic [7:0] dip0_reg, dip1_reg, dip2_reg;

    // Latches.
    logic [3:0] lfo_reg, lfo_next;
    logic [7:0] sound_reg, sound_next;
    logic       nmi_reg, nmi_next;
    logic       stars_reg, stars_next;
    logic [7:0] pitch_reg, pitch_next;
    logic       begun_reg, begun_next;

    // Decode stage: the accepted request, its RAM index and forwarding data.
    logic              s1_valid_reg;
    abd_req_t          s1_req_reg;
    logic              s1_ram_hit_reg;
    logic [RAM_AW-1:0] s1_ram_idx_reg;
    logic              s1_fwd_hit_reg;
    logic [7:0]        s1_fwd_data_reg;

    // Response register.
    logic     rsp_valid_reg;
    abd_rsp_t rsp_data_reg;
    abd_rsp_t rsp_next;

    logic              advance;
    logic              retire;
    logic              accept;
    logic [14:0]       in_a;
    logic              in_ram_hit;
    logic [RAM_AW-1:0] in_ram_idx;
    logic [14:0]       s1_a;
    logic              s1_write;
    logic [7:0]        ram_data;
    logic [7:0]        port0_val;
    logic [7:0]        port1_val;

    // The response register frees up when it is empty or being taken.
    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign retire    = s1_valid_reg && advance;
    assign req_stall = (state_reg != ST_RUN) || (s1_valid_reg && !advance);
    assign accept    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // Map the incoming address onto the three RAM windows.
    assign in_a = req_data.addr[14:0];

    always_comb
    begin
        in_ram_hit = 1'b1;
        in_ram_idx = '0;
        if (in_a[14:11] == RAM0_PAGE)
        begin
            in_ram_idx = RAM_AW'(in_a[10:0]);
        end
        else if (in_a[14:10] == RAM1_PAGE)
        begin
            in_ram_idx = RAM1_BASE + RAM_AW'(in_a[9:0]);
        end
        else if (in_a[14:11] == RAM2_PAGE)
        begin
            in_ram_idx = RAM2_BASE + RAM_AW'(in_a[10:0]);
        end
        else
        begin
            in_ram_hit = 1'b0;
        end
    end

    // Clearing sweep after reset, then normal operation.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == RAM_AW'(RAM_BYTES - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + RAM_AW'(1);
            end
        end
    end

    // RAM write port: the clearing sweep, or a write that retires.
    assign s1_a     = s1_req_reg.addr[14:0];
    assign s1_write = (s1_req_reg.cmd == CMD_WRITE) && s1_ram_hit_reg;

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = retire && s1_write;
            ram_waddr = s1_ram_idx_reg;
            ram_wdata = s1_req_reg.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            work_ram[ram_waddr] <= ram_wdata;
        end
        if (accept)
        begin
            ram_q_reg <= work_ram[in_ram_idx];
        end
    end

    // Decode stage. A write retiring in the same cycle to the same byte is
    // forwarded, as the RAM read above still sees the old contents.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg      <= req_data;
            s1_ram_hit_reg  <= in_ram_hit;
            s1_ram_idx_reg  <= in_ram_idx;
            s1_fwd_hit_reg  <= ram_we && (ram_waddr == in_ram_idx);
            s1_fwd_data_reg <= ram_wdata;
        end
    end

    assign ram_data  = s1_fwd_hit_reg ? s1_fwd_data_reg : ram_q_reg;
    assign port0_val = dip0_reg | {3'b000, s1_req_reg.btn_fire, s1_req_reg.btn_right,
                                   s1_req_reg.btn_left, 1'b0, s1_req_reg.btn_coin};
    assign port1_val = dip1_reg | {7'b0000000, s1_req_reg.btn_start};

    // Latch updates made by a write.
    always_comb
    begin
        lfo_next   = lfo_reg;
        sound_next = sound_reg;
        nmi_next   = nmi_reg;
        stars_next = stars_reg;
        pitch_next = pitch_reg;
        begun_next = begun_reg;
        if (s1_req_reg.cmd == CMD_WRITE)
        begin
            if (s1_write && (s1_a == START_MARK) && (s1_req_reg.wdata != START_IDLE))
            begin
                begun_next = 1'b1;
            end
            if ((s1_a[14:3] == LFO_GROUP) && s1_a[2])
            begin
                lfo_next[s1_a[1:0]] = s1_req_reg.wdata[0];
            end
            if (s1_a[14:3] == SOUND_GROUP)
            begin
                sound_next[s1_a[2:0]] = s1_req_reg.wdata[0];
            end
            if ((s1_a[14:3] == CTRL_GROUP) && (s1_a[2:0] == NMI_OFFSET))
            begin
                nmi_next = s1_req_reg.wdata[0];
            end
            if ((s1_a[14:3] == CTRL_GROUP) && (s1_a[2:0] == STARS_OFFSET))
            begin
                stars_next = s1_req_reg.wdata[0];
            end
            if (s1_a[14:11] == PITCH_PAGE)
            begin
                pitch_next = s1_req_reg.wdata;
            end
        end
    end

    // Response assembly.
    always_comb
    begin
        rsp_next              = '0;
        rsp_next.nmi_enable   = nmi_next;
        rsp_next.stars_on     = stars_next;
        rsp_next.started_flag = begun_next;
        rsp_next.vco_pitch    = pitch_next;
        rsp_next.lfo_bits     = lfo_next;
        rsp_next.sound_bits   = sound_next;
        case (s1_req_reg.cmd) inside
            CMD_READ, CMD_FETCH:
            begin
                if (!s1_a[14])
                begin
                    // Below 0x4000: the external ROM answers.
                    rsp_next.rom_request = 1'b1;
                    rsp_next.rom_address = s1_a[13:0];
                end
                else if (s1_req_reg.cmd == CMD_FETCH)
                begin
                    rsp_next.rdata = UNMAPPED_DATA;
                end
                else if (s1_ram_hit_reg)
                begin
                    rsp_next.rdata = ram_data;
                end
                else if (s1_a[14:11] == PORT0_PAGE)
                begin
                    rsp_next.rdata = port0_val;
                end
                else if (s1_a[14:11] == PORT1_PAGE)
                begin
                    rsp_next.rdata = port1_val;
                end
                else if (s1_a[14:11] == PORT2_PAGE)
                begin
                    rsp_next.rdata = dip2_reg;
                end
                else
                begin
                    rsp_next.rdata = UNMAPPED_DATA;
                end
            end
            default:
            begin
                // Writes and the unused code return zero data.
                rsp_next.rdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            lfo_reg       <= '0;
            sound_reg     <= '0;
            nmi_reg       <= 1'b0;
            stars_reg     <= 1'b0;
            pitch_reg     <= '0;
            begun_reg     <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
            if (retire)
            begin
                lfo_reg   <= lfo_next;
                sound_reg <= sound_next;
                nmi_reg   <= nmi_next;
                stars_reg <= stars_next;
                pitch_reg <= pitch_next;
                begun_reg <= begun_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (retire)
        begin
            rsp_data_reg <= rsp_next;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dip0_reg <= '0;
            dip1_reg <= '0;
            dip2_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DIP_PORT0: dip0_reg <= cfg_data;
                CFG_DIP_PORT1: dip1_reg <= cfg_data;
                CFG_DIP_PORT2: dip2_reg <= cfg_data;
                default:
                begin
                    dip0_reg <= dip0_reg;
                end
            endcase
        end
    end

endmodule

@@ src/abd_checker.sv @@
`timescale 1ns / 1ps

module abd_checker
    import abd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_stall,
    input logic       rsp_valid,
    input logic       rsp_stall,
    input abd_rsp_t   rsp_data
);

    // A stalled response holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("stalled response changed");

    // A new response always follows an accepted request through the decode stage.
    a_rsp_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
        else $error("response without matching request");

    // The game-started flag never falls once reported.
    a_started_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.started_flag |=> !rsp_valid || rsp_data.started_flag)
        else $error("started flag cleared");

    // Requests are held off, with no response valid, as reset is released and the RAM clear begins.
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> req_stall && !rsp_valid)
        else $error("request taken during RAM clear");

endmodule

bind arcade_bus_decoder abd_checker u_abd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import abd_pkg::*;

    // The bus has no name for the fourth command code. The block treats it
    // as no access at all.
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam int ITEMS_PER_PHASE = 312;
    // A request stalled through the whole RAM clearing pass after reset must
    // not trip the watchdog, so the limit is that pass with a wide margin.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    abd_req_t req_data = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    abd_rsp_t rsp_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = CFG_DIP_PORT0;
    logic [7:0] cfg_data = 8'h00;

    // One row of stimulus: the request itself and, for rows whose outcome is
    // obvious, the response typed in by hand.
    typedef struct {
        abd_req_t bus;
        bit fixed;
        abd_rsp_t rsp;
    } row_t;

    row_t directed_rows[$];
    row_t presented_rows[$];
    abd_rsp_t expected_rsp[$];

    // Shadow copy of the decoder state, kept in step with accepted requests.
    logic [7:0] shadow_ram [0:RAM_BYTES-1];
    logic [3:0] shadow_lfo;
    logic [7:0] shadow_sound;
    logic shadow_nmi;
    logic shadow_stars;
    logic [7:0] shadow_pitch;
    logic shadow_begun;
    logic [7:0] dip_value [0:2];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int err_count = 0;
    int rsp_count = 0;
    int quiet_cycles = 0;

    arcade_bus_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Work RAM index for a 15-bit address, or -1 outside the three windows.
    function automatic int ram_slot(input logic [14:0] a);
        if (a[14:11] == 4'b1000)
        begin
            return int'(a) - 'h4000;
        end
        if (a[14:10] == 5'b10100)
        begin
            return int'(a) - 'h5000 + 'h0800;
        end
        if (a[14:11] == 4'b1011)
        begin
            return int'(a) - 'h5800 + 'h0C00;
        end
        return -1;
    endfunction

    // Applies one bus access to the shadow state and returns the response
    // that the decoder should give for it.
    function automatic abd_rsp_t predict_access(input abd_req_t r);
        logic [14:0] a;
        logic [7:0] v;
        abd_rsp_t o;
        int slot;
        a = r.addr[14:0];
        v = r.wdata;
        o = '0;
        slot = ram_slot(a);
        if (r.cmd == CMD_READ || r.cmd == CMD_FETCH)
        begin
            if (a < 15'h4000)
            begin
                o.rom_request = 1'b1;
                o.rom_address = a[13:0];
            end
            else if (r.cmd == CMD_FETCH)
            begin
                // Opcode fetches are only ever served from ROM.
                o.rdata = 8'hFF;
            end
            else if (slot >= 0)
            begin
                o.rdata = shadow_ram[slot];
            end
            else if (a[14:11] == 4'b1100)
            begin
                o.rdata = dip_value[0] | {3'b000, r.btn_fire, r.btn_right, r.btn_left,
                                          1'b0, r.btn_coin};
            end
            else if (a[14:11] == 4'b1101)
            begin
                o.rdata = dip_value[1] | {7'b0000000, r.btn_start};
            end
            else if (a[14:11] == 4'b1110)
            begin
                o.rdata = dip_value[2];
            end
            else
            begin
                o.rdata = 8'hFF;
            end
        end
        else if (r.cmd == CMD_WRITE)
        begin
            if (slot >= 0)
            begin
                // The game marks the end of attract mode by storing anything
                // other than the idle value at one particular RAM byte.
                if (a == 15'h5320 && v != 8'h10)
                begin
                    shadow_begun = 1'b1;
                end
                shadow_ram[slot] = v;
            end
            else if (a[14:3] == 12'hC00)
            begin
                if (a[2])
                begin
                    shadow_lfo[a[1:0]] = v[0];
                end
            end
            else if (a[14:3] == 12'hD00)
            begin
                shadow_sound[a[2:0]] = v[0];
            end
            else if (a[14:3] == 12'hE00)
            begin
                if (a[2:0] == 3'd1)
                begin
                    shadow_nmi = v[0];
                end
                if (a[2:0] == 3'd4)
                begin
                    shadow_stars = v[0];
                end
            end
            else if (a[14:11] == 4'b1111)
            begin
                shadow_pitch = v;
            end
        end
        o.nmi_enable = shadow_nmi;
        o.stars_on = shadow_stars;
        o.started_flag = shadow_begun;
        o.vco_pitch = shadow_pitch;
        o.lfo_bits = shadow_lfo;
        o.sound_bits = shadow_sound;
        return o;
    endfunction

    // A response with every latch still at its reset value.
    function automatic abd_rsp_t bus_only(input logic [7:0] rdata, input logic rom_req,
                                          input logic [13:0] rom_addr);
        abd_rsp_t o;
        o = '0;
        o.rdata = rdata;
        o.rom_request = rom_req;
        o.rom_address = rom_addr;
        return o;
    endfunction

    task automatic add_row(input logic [1:0] cmd, input logic [15:0] addr,
                           input logic [7:0] wdata, input logic [4:0] btns,
                           input bit fixed, input abd_rsp_t rsp);
        row_t row;
        row.bus.cmd = cmd;
        row.bus.addr = addr;
        row.bus.wdata = wdata;
        {row.bus.btn_coin, row.bus.btn_left, row.bus.btn_right,
         row.bus.btn_fire, row.bus.btn_start} = btns;
        row.fixed = fixed;
        row.rsp = rsp;
        directed_rows.push_back(row);
    endtask

    // Random accesses, aimed mostly at the decoded regions and at a handful
    // of RAM bytes near the window edges so that reads find earlier writes.
    function automatic row_t random_access();
        row_t row;
        int sel;
        sel = $urandom_range(99);
        row.fixed = 1'b0;
        row.rsp = '0;
        if (sel < 10)
        begin
            row.bus.cmd = CMD_FETCH;
        end
        else if (sel < 45)
        begin
            row.bus.cmd = CMD_READ;
        end
        else if (sel < 95)
        begin
            row.bus.cmd = CMD_WRITE;
        end
        else
        begin
            row.bus.cmd = CMD_NONE;
        end
        row.bus.wdata = 8'($urandom_range(255));
        sel = $urandom_range(99);
        if (sel < 8)
        begin
            row.bus.addr = 16'($urandom_range('h3FFF));
        end
        else if (sel < 38)
        begin
            case ($urandom_range(5))
                0: row.bus.addr = 16'h4000 + 16'($urandom_range(7));
                1: row.bus.addr = 16'h47F8 + 16'($urandom_range(7));
                2: row.bus.addr = 16'h5000 + 16'($urandom_range(7));
                3: row.bus.addr = 16'h53F8 + 16'($urandom_range(7));
                4: row.bus.addr = 16'h5800 + 16'($urandom_range(7));
                default: row.bus.addr = 16'h5FF8 + 16'($urandom_range(7));
            endcase
        end
        else if (sel < 48)
        begin
            case ($urandom_range(2))
                0: row.bus.addr = 16'h4000 + 16'($urandom_range('h7FF));
                1: row.bus.addr = 16'h5000 + 16'($urandom_range('h3FF));
                default: row.bus.addr = 16'h5800 + 16'($urandom_range('h7FF));
            endcase
        end
        else if (sel < 58)
        begin
            row.bus.addr = 16'h6000 + 16'($urandom_range(15));
        end
        else if (sel < 68)
        begin
            row.bus.addr = 16'h6800 + 16'($urandom_range(15));
        end
        else if (sel < 76)
        begin
            row.bus.addr = 16'h7000 + 16'($urandom_range(15));
        end
        else if (sel < 82)
        begin
            row.bus.addr = 16'h7800 + 16'($urandom_range('h7FF));
        end
        else if (sel < 86)
        begin
            row.bus.addr = 16'h5320;
            if ($urandom_range(1) == 0)
            begin
                row.bus.wdata = 8'h10;
            end
        end
        else
        begin
            row.bus.addr = 16'($urandom_range('hFFFF));
        end
        // The top address bit is a mirror bit and must not matter.
        row.bus.addr[15] = 1'($urandom_range(1));
        {row.bus.btn_coin, row.bus.btn_left, row.bus.btn_right,
         row.bus.btn_fire, row.bus.btn_start} = 5'($urandom_range(31));
        return row;
    endfunction

    // Presents one request and returns at the edge where it is taken. Valid
    // stays high into the next request unless the sender chooses to idle.
    task automatic send_request(input row_t row);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        presented_rows.push_back(row);
        req_valid <= 1'b1;
        req_data <= row.bus;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Writes the three DIP registers in one burst on the configuration channel.
    task automatic write_dips(input logic [7:0] p0, input logic [7:0] p1,
                              input logic [7:0] p2);
        logic [7:0] vals [0:2];
        vals[0] = p0;
        vals[1] = p1;
        vals[2] = p2;
        cfg_valid <= 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            cfg_index <= 2'(i);
            cfg_data <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
            dip_value[i] = vals[i];
        end
        cfg_valid <= 1'b0;
    endtask

    // Waits until every request has been answered, then lets the pipeline
    // settle before anything else happens.
    task automatic wait_drained();
        while (presented_rows.size() != 0 || expected_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] response %0d: %s", $time, rsp_count, what);
        err_count++;
    endtask

    task automatic check_field(input string field, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s is %h, expected %h", field, got, want));
        end
    endtask

    // Receiver back-pressure. The percentage is set per phase by the main
    // sequence; a value of zero gives stretches with no stalling at all.
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    // Both handshakes are sampled here, at the edge, from values that settled
    // before it. A request taken at this edge gets its expected response
    // queued before any response taken at the same edge is checked.
    always @(posedge clk)
    begin : monitor
        row_t row;
        abd_rsp_t want;
        abd_rsp_t predicted;
        if (rst_n && req_valid && !req_stall)
        begin
            row = presented_rows.pop_front();
            predicted = predict_access(req_data);
            expected_rsp.push_back(row.fixed ? row.rsp : predicted);
        end
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                report_mismatch("response with no request outstanding");
            end
            else
            begin
                want = expected_rsp.pop_front();
                check_field("rdata", 16'(rsp_data.rdata), 16'(want.rdata));
                check_field("rom_request", 16'(rsp_data.rom_request),
                            16'(want.rom_request));
                check_field("rom_address", 16'(rsp_data.rom_address),
                            16'(want.rom_address));
                check_field("nmi_enable", 16'(rsp_data.nmi_enable), 16'(want.nmi_enable));
                check_field("stars_on", 16'(rsp_data.stars_on), 16'(want.stars_on));
                check_field("started_flag", 16'(rsp_data.started_flag),
                            16'(want.started_flag));
                check_field("vco_pitch", 16'(rsp_data.vco_pitch), 16'(want.vco_pitch));
                check_field("lfo_bits", 16'(rsp_data.lfo_bits), 16'(want.lfo_bits));
                check_field("sound_bits", 16'(rsp_data.sound_bits), 16'(want.sound_bits));
            end
            rsp_count++;
        end
    end

    // Watchdog: any edge at which nothing at all is taken counts towards the
    // limit, and any handshake resets it.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : main
        int send_pct [0:3];
        int recv_pct [0:3];
        foreach (shadow_ram[i])
        begin
            shadow_ram[i] = 8'h00;
        end
        shadow_lfo = 4'h0;
        shadow_sound = 8'h00;
        shadow_nmi = 1'b0;
        shadow_stars = 1'b0;
        shadow_pitch = 8'h00;
        shadow_begun = 1'b0;
        dip_value[0] = 8'h00;
        dip_value[1] = 8'h00;
        dip_value[2] = 8'h00;

        // Idling in the four random phases: none, a sender that is idle most
        // of the time, a receiver that stalls most of the time, and light
        // idling on both sides together.
        send_pct[0] = 0;
        recv_pct[0] = 0;
        send_pct[1] = 70;
        recv_pct[1] = 0;
        send_pct[2] = 0;
        recv_pct[2] = 70;
        send_pct[3] = 13;
        recv_pct[3] = 13;

        // The directed rows. The first twelve run straight after reset, so
        // every latch is still clear and their responses can be written down
        // directly; the rest rely on the shadow state.
        add_row(CMD_READ, 16'h0000, 8'h00, 5'b00000, 1, bus_only(8'h00, 1'b1, 14'h0000));
        add_row(CMD_FETCH, 16'hFFFF, 8'hFF, 5'b11111, 1, bus_only(8'hFF, 1'b0, 14'h0000));
        add_row(CMD_READ, 16'hBFFF, 8'h00, 5'b00000, 1, bus_only(8'h00, 1'b1, 14'h3FFF));
        add_row(CMD_FETCH, 16'h3FFF, 8'h00, 5'b00000, 1, bus_only(8'h00, 1'b1, 14'h3FFF));
        add_row(CMD_READ, 16'h4000, 8'h00, 5'b00000, 1, bus_only(8'h00, 1'b0, 14'h0000));
        // Holes in the map read back as all ones.
        add_row(CMD_READ, 16'h4800, 8'h00, 5'b00000, 1, bus_only(8'hFF, 1'b0, 14'h0000));
        add_row(CMD_READ, 16'h5400, 8'h00, 5'b00000, 1, bus_only(8'hFF, 1'b0, 14'h0000));
        add_row(CMD_READ, 16'h7800, 8'h00, 5'b00000, 1, bus_only(8'hFF, 1'b0, 14'h0000));
        // Input ports with every button pressed on top of the DIP settings.
        add_row(CMD_READ, 16'h6000, 8'h00, 5'b11111, 1, bus_only(8'h1D, 1'b0, 14'h0000));
        add_row(CMD_READ, 16'hE800, 8'h00, 5'b11111, 1, bus_only(8'h01, 1'b0, 14'h0000));
        add_row(CMD_READ, 16'h77FF, 8'h00, 5'b11111, 1, bus_only(8'hA5, 1'b0, 14'h0000));
        add_row(CMD_NONE, 16'h4000, 8'hFF, 5'b00000, 1, bus_only(8'h00, 1'b0, 14'h0000));
        // A write followed at once by a read of the same byte.
        add_row(CMD_WRITE, 16'h47FF, 8'hFF, 5'b00000, 0, '0);
        add_row(CMD_READ, 16'hC7FF, 8'h00, 5'b00000, 0, '0);
        // The idle value at the start marker leaves the flag clear; anything
        // else, even through the mirror, sets it for good.
        add_row(CMD_WRITE, 16'h5320, 8'h10, 5'b00000, 0, '0);
        add_row(CMD_WRITE, 16'hD320, 8'h11, 5'b00000, 0, '0);
        add_row(CMD_WRITE, 16'h5FFF, 8'h5A, 5'b00000, 0, '0);
        add_row(CMD_FETCH, 16'h5FFF, 8'h00, 5'b00000, 0, '0);
        add_row(CMD_WRITE, 16'h6007, 8'h01, 5'b00000, 0, '0);
        add_row(CMD_WRITE, 16'h6003, 8'h01, 5'b00000, 0, '0);
        add_row(CMD_WRITE, 16'h6807, 8'hFF, 5'b00000, 0, '0);
        add_row(CMD_WRITE, 16'h7001, 8'h01, 5'b00000, 0, '0);
        add_row(CMD_WRITE, 16'h7004, 8'h01, 5'b00000, 0, '0);
        add_row(CMD_WRITE, 16'hFFFF, 8'h80, 5'b00000, 0, '0);
        add_row(CMD_WRITE, 16'h0000, 8'h55, 5'b00000, 0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The configuration channel is open while the RAM is being cleared.
        write_dips(8'h00, 8'h00, 8'hA5);
        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i]);
        end
        req_valid <= 1'b0;

        for (int phase = 0; phase < 4; phase++)
        begin
            wait_drained();
            case (phase)
                0: write_dips(8'hFF, 8'hFF, 8'hFF);
                1: write_dips(8'h00, 8'h00, 8'h00);
                default: write_dips(8'($urandom_range(255)), 8'($urandom_range(255)),
                                    8'($urandom_range(255)));
            endcase
            send_idle_pct = send_pct[phase];
            stall_pct = recv_pct[phase];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                send_request(random_access());
            end
            req_valid <= 1'b0;
        end

        wait_drained();
        if (err_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/abd_pkg.sv
src/arcade_bus_decoder.sv
src/abd_checker.sv
dv/testbench.sv
